// ===== rtl/jemc_pkg.sv =====
`default_nettype none

package jemc_pkg;

  localparam int unsigned LVL_W  = 7;
  localparam int unsigned LVL_AW = 3;

  localparam logic [15:0]      NOT_PRESENT = 16'd32511;
  localparam logic [LVL_W-1:0] LEVEL_MAX   = 7'd127;

  localparam logic [7:0] STICK1_CODE_BASE = 8'd21;
  localparam logic [7:0] STICK2_CODE_BASE = 8'd41;
  localparam logic [7:0] MOVE_BTN_OFFSET  = 8'd8;

  typedef enum logic [2:0] {
    ACT_S1_BTN_UP   = 3'd0,
    ACT_S1_BTN_DOWN = 3'd1,
    ACT_S2_BTN_UP   = 3'd2,
    ACT_S2_BTN_DOWN = 3'd3,
    ACT_S1_MOVE     = 3'd4,
    ACT_S1_Z        = 3'd5,
    ACT_S2_MOVE     = 3'd6,
    ACT_S2_Z        = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    CFG_SCENE      = 3'd0,
    CFG_RELATIVE   = 3'd1,
    CFG_HORIZONTAL = 3'd2,
    CFG_DIRECT_BTN = 3'd3,
    CFG_STEP_SIZE  = 3'd4,
    CFG_GROUP_ONE  = 3'd5,
    CFG_GROUP_TWO  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic              en;
    logic [LVL_AW-1:0] addr;
  } lvl_rd_t;

  typedef struct packed {
    logic              en;
    logic [LVL_AW-1:0] addr;
    logic [LVL_W-1:0]  data;
  } lvl_wr_t;

  function automatic logic [7:0] axis_code(input logic [LVL_AW-1:0] k);
    logic [7:0] base;
    base = k[LVL_AW-1] ? STICK2_CODE_BASE : STICK1_CODE_BASE;
    return base + {6'd0, k[1:0]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/jemc_if.sv =====
`default_nettype none

interface jemc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  button_bits;
  logic [15:0] x_pos;
  logic [15:0] y_pos;

  modport source (output valid, action, button_bits, x_pos, y_pos, input ready);
  modport sink   (input valid, action, button_bits, x_pos, y_pos, output ready);
endinterface

interface jemc_out_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [7:0] scene_out;
  logic [7:0] control_id;
  logic [6:0] control_value;
  logic       direction;

  modport source (output valid, valid_res, scene_out, control_id, control_value,
                  direction, input ready);
  modport sink   (input valid, valid_res, scene_out, control_id, control_value,
                  direction, output ready);
endinterface

`default_nettype wire

// ===== rtl/jemc_lvl_mem.sv =====
`default_nettype none

module jemc_lvl_mem
  import jemc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lvl_rd_t          rd_i,
  input  wire lvl_wr_t          wr_i,
  output logic [LVL_W-1:0]      rd_data_o
);

  localparam int unsigned DEPTH = 1 << LVL_AW;

  logic [LVL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [LVL_W-1:0] rd_data_q;
  logic             rd_vld_q;
  logic             bypass;

  assign bypass = wr_i.en && (wr_i.addr == rd_i.addr);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= bypass ? wr_i.data : mem[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_vld_q <= bypass || vld_q[rd_i.addr];
      end
    end
  end

  // entries never written read as zero
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ===== rtl/joystick_event_to_midi_control.sv =====
// Turns joystick events into control records, one record per item. An item
// is taken every cycle when the output side keeps up; a record passes through
// stage 1 and the output register: the accept cycle reads the item's
// 7-bit axis level from an eight-entry one-read one-write memory; stage 1
// steps the level, writes it back and loads the output register when the
// output side can advance. A level written by one item and read by the very
// next item is bypassed at the memory read. Levels are zero after reset;
// configuration is to be written only while idle; the block does not enforce it.
`default_nettype none

module joystick_event_to_midi_control
  import jemc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  jemc_in_if.sink     in_ch,
  jemc_out_if.source  out_ch,
  input  wire logic   cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i
);

  // configuration
  logic [7:0]       scene_q;
  logic             rel_q;
  logic             horiz_q;
  logic             direct_q;
  logic [LVL_W-1:0] step_q;
  logic [7:0]       grp1_q;
  logic [7:0]       grp2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scene_q  <= '0;
      rel_q    <= 1'b0;
      horiz_q  <= 1'b0;
      direct_q <= 1'b0;
      step_q   <= 7'd1;
      grp1_q   <= '0;
      grp2_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SCENE:      scene_q  <= cfg_data_i;
        CFG_RELATIVE:   rel_q    <= cfg_data_i[0];
        CFG_HORIZONTAL: horiz_q  <= cfg_data_i[0];
        CFG_DIRECT_BTN: direct_q <= cfg_data_i[0];
        CFG_STEP_SIZE:  step_q   <= cfg_data_i[LVL_W-1:0];
        CFG_GROUP_ONE:  grp1_q   <= cfg_data_i;
        CFG_GROUP_TWO:  grp2_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake
  logic in_acc;
  logic adv;
  logic s1_vld_q;
  logic out_vld_q;

  assign adv          = !out_vld_q || out_ch.ready;
  assign in_ch.ready  = !s1_vld_q || adv;
  assign in_acc       = in_ch.valid && in_ch.ready;

  // level address of the incoming item
  logic              in_use_x;
  logic [LVL_AW-1:0] in_k;

  assign in_use_x = in_ch.x_pos != NOT_PRESENT;
  assign in_k     = {in_ch.action[1], in_ch.action[0], !in_use_x};

  // stage 1 item
  logic [2:0]  s1_action_q;
  logic [7:0]  s1_bits_q;
  logic [15:0] s1_x_q;
  logic [15:0] s1_y_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_action_q <= in_ch.action;
      s1_bits_q   <= in_ch.button_bits;
      s1_x_q      <= in_ch.x_pos;
      s1_y_q      <= in_ch.y_pos;
    end
  end

  lvl_rd_t          lvl_rd;
  lvl_wr_t          lvl_wr;
  logic [LVL_W-1:0] old_lvl;

  assign lvl_rd.en   = in_acc;
  assign lvl_rd.addr = in_k;

  jemc_lvl_mem u_lvl_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (lvl_rd),
    .wr_i      (lvl_wr),
    .rd_data_o (old_lvl)
  );

  // stage 1 compute
  logic              is_axis;
  logic              is_down;
  logic [3:0]        act;
  logic [3:0]        btn;
  logic [7:0]        btn_base;
  logic              use_x;
  logic [15:0]       pos;
  logic              pos_nz;
  logic              both_absent;
  logic [LVL_AW-1:0] k;
  logic [7:0]        stick_base;
  logic              up;
  logic              exempt;
  logic [7:0]        sum_up;
  logic [LVL_W-1:0]  nv;
  logic              res_ok;
  logic [7:0]        res_id;
  logic [LVL_W-1:0]  res_val;
  logic              res_dir;

  always_comb begin
    is_axis     = s1_action_q >= ACT_S1_MOVE;
    is_down     = s1_action_q[0];
    act         = s1_bits_q[3:0] | s1_bits_q[7:4];
    btn         = act & (~act + 4'd1);
    btn_base    = (s1_action_q < ACT_S2_BTN_UP) ? grp1_q : grp2_q;
    use_x       = s1_x_q != NOT_PRESENT;
    pos         = use_x ? s1_x_q : s1_y_q;
    pos_nz      = pos != '0;
    both_absent = !use_x && (s1_y_q == NOT_PRESENT);
    k           = {s1_action_q[1], s1_action_q[0], !use_x};
    stick_base  = s1_action_q[1] ? grp2_q : grp1_q;
    up          = use_x ? pos_nz : !pos_nz;
    exempt      = horiz_q && use_x && !s1_action_q[0];
    sum_up      = {1'b0, old_lvl} + {1'b0, step_q};
    if (up) begin
      nv = (sum_up < {1'b0, LEVEL_MAX}) ? sum_up[LVL_W-1:0] : LEVEL_MAX;
    end else begin
      nv = (old_lvl > step_q) ? old_lvl - step_q : '0;
    end

    res_ok      = 1'b0;
    res_id      = '0;
    res_val     = '0;
    res_dir     = 1'b0;
    lvl_wr.en   = 1'b0;
    lvl_wr.addr = k;
    lvl_wr.data = nv;

    if (!is_axis) begin
      if (btn != '0) begin
        res_ok  = 1'b1;
        res_id  = btn_base + {4'd0, btn};
        res_val = is_down ? LEVEL_MAX : '0;
        res_dir = rel_q && is_down;
      end
    end else if (!both_absent) begin
      if (direct_q && !rel_q) begin
        res_ok  = 1'b1;
        res_id  = stick_base + MOVE_BTN_OFFSET + {5'd0, k[1:0], 1'b1} + {7'd0, pos_nz};
        res_val = LEVEL_MAX;
      end else if (rel_q || exempt || old_lvl == '0 || old_lvl != nv) begin
        res_ok    = 1'b1;
        res_id    = axis_code(k);
        res_val   = nv;
        res_dir   = rel_q && pos_nz;
        lvl_wr.en = s1_vld_q && adv;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (adv) begin
        s1_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  logic             out_ok_q;
  logic [7:0]       out_scene_q;
  logic [7:0]       out_id_q;
  logic [LVL_W-1:0] out_val_q;
  logic             out_dir_q;

  always_ff @(posedge clk_i) begin
    if (adv && s1_vld_q) begin
      out_ok_q    <= res_ok;
      out_scene_q <= res_ok ? scene_q : '0;
      out_id_q    <= res_id;
      out_val_q   <= res_val;
      out_dir_q   <= res_dir;
    end
  end

  assign out_ch.valid         = out_vld_q;
  assign out_ch.valid_res     = out_ok_q;
  assign out_ch.scene_out     = out_scene_q;
  assign out_ch.control_id    = out_id_q;
  assign out_ch.control_value = out_val_q;
  assign out_ch.direction     = out_dir_q;

  // checks
  a_wr_only_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_wr.en |-> (s1_vld_q && adv && is_axis))
    else $error("level written without an advancing item");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_vld_q)
    else $error("accepted item lost before stage 1");

  a_empty_record_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.valid_res) |->
      (out_ch.scene_out == '0 && out_ch.control_id == '0 &&
       out_ch.control_value == '0 && !out_ch.direction))
    else $error("empty record carries nonzero fields");

endmodule

`default_nettype wire
